>>> rtl/core/assert_macros.svh
// assertion helper macros for the aes cbc core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at each rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/aes_cbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_cbc_pkg
// shared constants, tables and byte-level functions for the aes cbc core
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

  localparam int unsigned ROUND_COUNT = 10;
  localparam int unsigned KEY_WORDS   = 4 * (ROUND_COUNT + 1);
  localparam int unsigned KW_IDX_W    = $clog2(KEY_WORDS);
  localparam int unsigned RND_W       = $clog2(ROUND_COUNT + 1);

  localparam logic [2:0] CFG_KEY_HIGH = 3'd0;
  localparam logic [2:0] CFG_KEY_LOW  = 3'd1;
  localparam logic [2:0] CFG_IV_HIGH  = 3'd2;
  localparam logic [2:0] CFG_IV_LOW   = 3'd3;
  localparam logic [2:0] CFG_DECRYPT  = 3'd4;

  localparam logic [7:0] PAD_FULL = 8'h10;
  localparam logic [4:0] BYTES_FULL = 5'd16;

  typedef logic [127:0] blk_t;

  // round unit control
  typedef struct packed {
    logic       start;
    logic       decrypt;
    logic [RND_W-1:0] rnd;
  } rnd_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox_f(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    sbox_f = t[x];
  endfunction

  function automatic logic [7:0] sbox_i(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    sbox_i = t[x];
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input blk_t b, input int i);
    byte_of = b[127-8*i -: 8];
  endfunction

endpackage

>>> rtl/core/aes_cbc_keyexp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_cbc_keyexp
// round key store, filled one 128-bit round key a cycle from the cipher key
// ----------------------------------------------------------------------------
module aes_cbc_keyexp (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [aes_cbc_pkg::RND_W-1:0] rd_rnd,
  output logic [127:0] rd_key,
  output logic         busy
);
  localparam int unsigned NK = aes_cbc_pkg::ROUND_COUNT + 1;
  localparam int unsigned RW = aes_cbc_pkg::RND_W;

  logic [127:0] rk_r [NK];
  logic [127:0] prev_r, nk_nxt;
  logic [RW-1:0] idx_r, idx_nxt;
  logic busy_r, busy_nxt;
  logic [7:0] rc_r, rc_nxt;
  logic [31:0] t, w0, w1, w2, w3;

  // next round key from the previous one
  always_comb begin
    t = {aes_cbc_pkg::sbox_f(prev_r[23:16]), aes_cbc_pkg::sbox_f(prev_r[15:8]),
         aes_cbc_pkg::sbox_f(prev_r[7:0]), aes_cbc_pkg::sbox_f(prev_r[31:24])};
    t = t ^ {rc_r, 24'd0};
    w0 = prev_r[127:96] ^ t;
    w1 = prev_r[95:64] ^ w0;
    w2 = prev_r[63:32] ^ w1;
    w3 = prev_r[31:0] ^ w2;
    nk_nxt = {w0, w1, w2, w3};
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    rc_nxt   = rc_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = RW'(1);
      rc_nxt   = 8'h01;
    end else if (busy_r) begin
      rc_nxt = aes_cbc_pkg::xtime(rc_r);
      if (idx_r == RW'(aes_cbc_pkg::ROUND_COUNT)) busy_nxt = 1'b0;
      else idx_nxt = idx_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= RW'(1);
      rc_r   <= 8'h01;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      rc_r   <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      rk_r[0] <= '0;
    end else if (start) begin
      prev_r  <= key;
      rk_r[0] <= key;
    end else if (busy_r) begin
      prev_r      <= nk_nxt;
      rk_r[idx_r] <= nk_nxt;
    end
  end

  assign rd_key = rk_r[rd_rnd];
  assign busy = busy_r;
endmodule

>>> rtl/core/aes_cbc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_cbc_round
// one shared round unit, forward or inverse, plus state register
// ----------------------------------------------------------------------------
module aes_cbc_round (
  input  logic         clk,
  input  logic         load,
  input  logic [127:0] load_val,
  input  aes_cbc_pkg::rnd_ctl_t ctl,
  input  logic [127:0] rkey,
  output logic [127:0] state
);
  logic [127:0] st_r, st_nxt;
  logic [7:0] s [16];
  logic [7:0] a [16];
  logic [7:0] m [16];
  logic last;
  logic [7:0] x2, x4, x8, b0, b1, b2, b3;

  always_comb begin
    last = ctl.decrypt ? (ctl.rnd == aes_cbc_pkg::RND_W'(1))
                       : (ctl.rnd == aes_cbc_pkg::RND_W'(aes_cbc_pkg::ROUND_COUNT));
    for (int i = 0; i < 16; i++) s[i] = aes_cbc_pkg::byte_of(st_r, i);
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl.decrypt) a[4*c+r] = aes_cbc_pkg::sbox_i(s[4*((c+4-r)&3)+r]);
        else a[4*c+r] = aes_cbc_pkg::sbox_f(s[4*((c+r)&3)+r]);
      end
    end
    if (ctl.decrypt)
      for (int i = 0; i < 16; i++) a[i] = a[i] ^ rkey[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        m[4*c+i] = 8'd0;
        for (int k = 0; k < 4; k++) begin
          b0 = a[4*c+k];
          x2 = aes_cbc_pkg::xtime(b0);
          x4 = aes_cbc_pkg::xtime(x2);
          x8 = aes_cbc_pkg::xtime(x4);
          unique case ((k - i + 4) & 3)
            0: begin b1 = x2; b2 = x8 ^ x4 ^ x2; end
            1: begin b1 = x2 ^ b0; b2 = x8 ^ x2 ^ b0; end
            2: begin b1 = b0; b2 = x8 ^ x4 ^ b0; end
            default: begin b1 = b0; b2 = x8 ^ b0; end
          endcase
          b3 = ctl.decrypt ? b2 : b1;
          m[4*c+i] = m[4*c+i] ^ b3;
        end
      end
    end
    if (last) for (int i = 0; i < 16; i++) m[i] = a[i];
    if (!ctl.decrypt)
      for (int i = 0; i < 16; i++) m[i] = m[i] ^ rkey[127-8*i -: 8];
    for (int i = 0; i < 16; i++) st_nxt[127-8*i -: 8] = m[i];
  end

  always_ff @(posedge clk) begin
    if (load) st_r <= load_val ^ rkey;
    else if (ctl.start) st_r <= st_nxt;
  end

  assign state = st_r;
endmodule

>>> rtl/core/aes128_cbc_cipher_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// aes128_cbc_cipher_top
// aes-128 cbc encrypt/decrypt core with pkcs7 pad and strip
// ----------------------------------------------------------------------------
// channel | dir | contents
// in_     | in  | tdata: block_high, block_low, byte_count; tuser: first; tlast: last
// out_    | out | tdata: out_high, out_low, valid_bytes; tlast: end_of_message
// cfg_    | in  | index 0..4, 64-bit data
// a block is processed as a key add on load, then ten passes of the round unit,
// then the result is registered; a full last block in encrypt mode
// runs a second pass for the pad block
// after reset and after each key write the key store fills, during which no
// beat is accepted
// the output register holds a result until taken; the core waits for it
module aes128_cbc_cipher_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,  // block_high, block_low, byte_count, pad
  input  logic         in_tuser,  // first_block
  input  logic         in_tlast,  // last_block
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata, // out_high, out_low, valid_bytes, pad
  output logic         out_tlast, // end_of_message
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;
  localparam int unsigned RW = aes_cbc_pkg::RND_W;

  // configuration
  logic [127:0] key_r, iv_r;
  logic decrypt_r;
  logic [127:0] chain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0; iv_r <= '0; decrypt_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes_cbc_pkg::CFG_KEY_HIGH: key_r[127:64] <= cfg_wdata;
        aes_cbc_pkg::CFG_KEY_LOW:  key_r[63:0]   <= cfg_wdata;
        aes_cbc_pkg::CFG_IV_HIGH:  iv_r[127:64]  <= cfg_wdata;
        aes_cbc_pkg::CFG_IV_LOW:   iv_r[63:0]    <= cfg_wdata;
        aes_cbc_pkg::CFG_DECRYPT:  decrypt_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic key_wr;
  logic key_wr_r;
  assign key_wr = cfg_we && (cfg_index == aes_cbc_pkg::CFG_KEY_HIGH ||
                             cfg_index == aes_cbc_pkg::CFG_KEY_LOW);
  always_ff @(posedge clk) begin
    if (!rst_n) key_wr_r <= 1'b0;
    else key_wr_r <= key_wr;
  end

  // sequencer
  logic [1:0] st_r, st_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic pad_pend_r, pad_pend_nxt;
  logic last_r, last_nxt;
  logic [127:0] cin_r, cin_nxt;   // ciphertext in, for decrypt chaining
  logic [127:0] chain_nxt;
  logic [127:0] res_r, res_nxt;
  logic [4:0] vb_r, vb_nxt;
  logic eom_r, eom_nxt;
  logic kbusy;
  logic in_fire;
  logic load;
  logic [127:0] load_val;
  logic [127:0] rkey, rstate;
  aes_cbc_pkg::rnd_ctl_t ctl;
  logic [RW-1:0] key_sel;
  logic out_tvalid_r;
  logic out_load;

  logic [127:0] in_blk, pad_blk, chv;
  logic [4:0] n_sat;
  logic [7:0] fin;

  assign in_blk = {in_tdata[63:0], in_tdata[127:64]};
  assign in_tready = (st_r == ST_IDLE) && !kbusy && !key_wr_r;
  assign in_fire = in_tvalid && in_tready;
  assign chv = in_tuser ? iv_r : chain_r;

  always_comb begin
    n_sat = (in_tdata[132:128] > 5'd16) ? 5'd16 : in_tdata[132:128];
    for (int i = 0; i < 16; i++)
      pad_blk[127-8*i -: 8] = (5'(i) < n_sat) ? aes_cbc_pkg::byte_of(in_blk, i)
                                              : 8'(5'd16 - n_sat);
  end

  always_comb begin
    load = 1'b0;
    load_val = '0;
    st_nxt = st_r; rnd_nxt = rnd_r; pad_pend_nxt = pad_pend_r; last_nxt = last_r;
    cin_nxt = cin_r; chain_nxt = chain_r; res_nxt = res_r; vb_nxt = vb_r; eom_nxt = eom_r;
    fin = 8'd0;
    ctl.start = (st_r == ST_RUN);
    ctl.decrypt = decrypt_r;
    ctl.rnd = rnd_r;
    key_sel = decrypt_r ? RW'(aes_cbc_pkg::ROUND_COUNT) : RW'(0);
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          last_nxt = in_tlast;
          pad_pend_nxt = 1'b0;
          cin_nxt = in_blk;
          chain_nxt = chv;
          rnd_nxt = decrypt_r ? RW'(aes_cbc_pkg::ROUND_COUNT) : RW'(1);
          st_nxt = ST_RUN;
          if (decrypt_r) load_val = in_blk;
          else if (!in_tlast) load_val = in_blk ^ chv;
          else if (n_sat == 5'd16) begin
            load_val = in_blk ^ chv;
            pad_pend_nxt = 1'b1;
          end else load_val = pad_blk ^ chv;
        end
      end
      ST_RUN: begin
        key_sel = decrypt_r ? rnd_r - RW'(1) : rnd_r;
        if (decrypt_r ? rnd_r == RW'(1) : rnd_r == RW'(aes_cbc_pkg::ROUND_COUNT))
          st_nxt = ST_OUT;
        else rnd_nxt = decrypt_r ? rnd_r - RW'(1) : rnd_r + RW'(1);
      end
      ST_OUT: begin
        if (!out_tvalid_r) begin
          if (decrypt_r) begin
            res_nxt = rstate ^ chain_r;
            chain_nxt = cin_r;
            fin = res_nxt[7:0];
            vb_nxt = !last_r ? aes_cbc_pkg::BYTES_FULL
                   : (fin > 8'd16) ? 5'd0 : 5'(8'd16 - fin);
            eom_nxt = last_r;
            st_nxt = ST_IDLE;
          end else begin
            res_nxt = rstate;
            chain_nxt = rstate;
            vb_nxt = aes_cbc_pkg::BYTES_FULL;
            eom_nxt = last_r && !pad_pend_r;
            if (pad_pend_r) begin
              load = 1'b1;
              load_val = {16{aes_cbc_pkg::PAD_FULL}} ^ rstate;
              pad_pend_nxt = 1'b0;
              rnd_nxt = RW'(1);
              st_nxt = ST_RUN;
            end else st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_load = (st_r == ST_OUT) && !out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; rnd_r <= '0; pad_pend_r <= 1'b0; last_r <= 1'b0;
      chain_r <= '0; out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rnd_r <= rnd_nxt; pad_pend_r <= pad_pend_nxt; last_r <= last_nxt;
      chain_r <= chain_nxt;
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cin_r <= cin_nxt; res_r <= res_nxt; vb_r <= vb_nxt; eom_r <= eom_nxt;
  end

  aes_cbc_keyexp u_keyexp (
    .clk(clk), .rst_n(rst_n), .start(key_wr_r), .key(key_r),
    .rd_rnd(key_sel), .rd_key(rkey), .busy(kbusy)
  );

  aes_cbc_round u_round (
    .clk(clk), .load(load), .load_val(load_val), .ctl(ctl), .rkey(rkey), .state(rstate)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata = {3'd0, vb_r, res_r[63:0], res_r[127:64]};
  assign out_tlast = eom_r;

  `ASSERT_CLK(a_busy_no_accept, !(in_fire && kbusy), "beat accepted during key fill")
  `ASSERT_NEXT(a_fire_runs, in_fire, st_r == ST_RUN, "accepted beat did not start rounds")
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
endmodule

>>> dv/aes128_cbc_cipher_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cbc_cipher_top_tb
// self-checking bench: an in-bench aes-128 cbc model with pkcs7 handling
// predicts every output beat; directed corner blocks are followed by random
// messages under several key, vector and direction settings, with random
// gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
module aes128_cbc_cipher_top_tb;

  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  cnt;
    logic        first;
    logic        last;
  } blk_beat_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    logic        eom;
  } out_beat_t;

  // cbc model with its own key schedule, chaining value and expected beats
  class cbc_scoreboard;
    logic [7:0]  fwd_box [256];
    logic [7:0]  inv_box [256];
    logic [31:0] rkey [aes_cbc_pkg::KEY_WORDS];
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic        decrypt;
    aes_cbc_pkg::blk_t chain;
    out_beat_t   pending [$];
    int          errors, results, accepted;

    function new();
      logic [7:0] inv, b;
      for (int x = 0; x < 256; x++) begin
        inv = 8'h00;
        for (int y = 1; y < 256; y++)
          if (x != 0 && gmul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
        b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
            {inv[3:0], inv[7:4]} ^ 8'h63;
        fwd_box[x] = b;
        inv_box[b] = 8'(x);
      end
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
      decrypt = 1'b0;
      chain = '0;
      errors = 0; results = 0; accepted = 0;
      expand();
    endfunction

    function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (b[0]) acc ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        b = b >> 1;
      end
      return acc;
    endfunction

    function void expand();
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      rkey[0] = key_hi[63:32]; rkey[1] = key_hi[31:0];
      rkey[2] = key_lo[63:32]; rkey[3] = key_lo[31:0];
      for (int i = 4; i < aes_cbc_pkg::KEY_WORDS; i++) begin
        t = rkey[i-1];
        if (i % 4 == 0) begin
          t = {t[23:0], t[31:24]};
          t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
          t ^= {rc, 24'h0};
          rc = gmul(rc, 8'h02);
        end
        rkey[i] = rkey[i-4] ^ t;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        aes_cbc_pkg::CFG_KEY_HIGH: begin key_hi = val; expand(); end
        aes_cbc_pkg::CFG_KEY_LOW:  begin key_lo = val; expand(); end
        aes_cbc_pkg::CFG_IV_HIGH:  iv_hi = val;
        aes_cbc_pkg::CFG_IV_LOW:   iv_lo = val;
        aes_cbc_pkg::CFG_DECRYPT:  decrypt = val[0];
        default: ;
      endcase
    endfunction

    function aes_cbc_pkg::blk_t add_rkey(aes_cbc_pkg::blk_t b, int r);
      return b ^ {rkey[4*r], rkey[4*r+1], rkey[4*r+2], rkey[4*r+3]};
    endfunction

    function aes_cbc_pkg::blk_t subst(aes_cbc_pkg::blk_t b, bit inverse);
      for (int i = 0; i < 16; i++)
        b[127-8*i -: 8] = inverse ? inv_box[b[127-8*i -: 8]] : fwd_box[b[127-8*i -: 8]];
      return b;
    endfunction

    function aes_cbc_pkg::blk_t rows(aes_cbc_pkg::blk_t b, bit inverse);
      aes_cbc_pkg::blk_t o;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          o[127-8*(4*c+r) -: 8] = b[127-8*(4*((inverse ? c + 4 - r : c + r) % 4)+r) -: 8];
      return o;
    endfunction

    function aes_cbc_pkg::blk_t columns(aes_cbc_pkg::blk_t b, bit inverse);
      logic [7:0] coef [4];
      logic [7:0] t;
      aes_cbc_pkg::blk_t o;
      if (inverse) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) begin
          t = 8'h00;
          for (int k = 0; k < 4; k++)
            t ^= gmul(coef[(k - i + 4) % 4], b[127-8*(4*c+k) -: 8]);
          o[127-8*(4*c+i) -: 8] = t;
        end
      return o;
    endfunction

    function aes_cbc_pkg::blk_t encipher(aes_cbc_pkg::blk_t b);
      b = add_rkey(b, 0);
      for (int r = 1; r <= int'(aes_cbc_pkg::ROUND_COUNT); r++) begin
        b = rows(subst(b, 0), 0);
        if (r < int'(aes_cbc_pkg::ROUND_COUNT)) b = columns(b, 0);
        b = add_rkey(b, r);
      end
      return b;
    endfunction

    function aes_cbc_pkg::blk_t decipher(aes_cbc_pkg::blk_t b);
      b = add_rkey(b, int'(aes_cbc_pkg::ROUND_COUNT));
      for (int r = int'(aes_cbc_pkg::ROUND_COUNT); r > 0; r--) begin
        b = add_rkey(subst(rows(b, 1), 1), r - 1);
        if (r > 1) b = columns(b, 1);
      end
      return b;
    endfunction

    // ciphertext that decrypts to plain at the current chaining point
    function aes_cbc_pkg::blk_t cipher_for(aes_cbc_pkg::blk_t plain, logic first);
      return encipher(plain ^ (first ? {iv_hi, iv_lo} : chain));
    endfunction

    function void push_enc(aes_cbc_pkg::blk_t b, logic eom);
      out_beat_t e;
      chain = encipher(b ^ chain);
      e.hi = chain[127:64]; e.lo = chain[63:0]; e.nbytes = aes_cbc_pkg::BYTES_FULL;
      e.eom = eom;
      pending.push_back(e);
    endfunction

    function void note_block(blk_beat_t it);
      aes_cbc_pkg::blk_t b, p;
      out_beat_t e;
      int n;
      accepted++;
      if (it.first) chain = {iv_hi, iv_lo};
      b = {it.hi, it.lo};
      if (decrypt) begin
        p = decipher(b) ^ chain;
        chain = b;
        e.hi = p[127:64]; e.lo = p[63:0]; e.eom = it.last;
        e.nbytes = !it.last ? aes_cbc_pkg::BYTES_FULL
                 : (p[7:0] > 8'd16) ? 5'd0 : 5'(16 - int'(p[7:0]));
        pending.push_back(e);
      end else if (!it.last) begin
        push_enc(b, 1'b0);
      end else begin
        n = (it.cnt > 5'd16) ? 16 : int'(it.cnt);
        if (n == 16) begin
          push_enc(b, 1'b0);
          push_enc({16{aes_cbc_pkg::PAD_FULL}}, 1'b1);
        end else begin
          for (int i = n; i < 16; i++) b[127-8*i -: 8] = 8'(16 - n);
          push_enc(b, 1'b1);
        end
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %h want %h", results, what, got, want);
    endtask

    task check_result(out_beat_t got);
      out_beat_t e;
      results++;
      if (pending.size() == 0) begin
        report("unexpected beat", got.hi, 64'd0);
        return;
      end
      e = pending.pop_front();
      if (got.hi !== e.hi) report("out_high", got.hi, e.hi);
      if (got.lo !== e.lo) report("out_low", got.lo, e.lo);
      if (got.nbytes !== e.nbytes) report("valid_bytes", 64'(got.nbytes), 64'(e.nbytes));
      if (got.eom !== e.eom) report("end_of_message", 64'(got.eom), 64'(e.eom));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;   // block_high, block_low, byte_count, pad
  logic         in_tuser = 1'b0; // first_block
  logic         in_tlast = 1'b0; // last_block
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;      // out_high, out_low, valid_bytes, pad
  logic         out_tlast;      // end_of_message
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = aes_cbc_pkg::CFG_KEY_HIGH;
  logic [63:0]  cfg_wdata = '0;

  cbc_scoreboard sb = new();
  int  idle_cycles = 0;
  int  messages;

  aes128_cbc_cipher_top uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor plus watchdog on handshake activity
  always @(posedge clk) begin
    out_beat_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.hi = out_tdata[63:0];
      got.lo = out_tdata[127:64];
      got.nbytes = out_tdata[132:128];
      got.eom = out_tlast;
      sb.check_result(got);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // output-side stall pattern, redrawn for every beat
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = $urandom_range(0, 18);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // register write, only called while the core is idle
  task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic setup(logic [63:0] kh, logic [63:0] kl, logic [63:0] vh, logic [63:0] vl,
                       logic dec);
    write_cfg(aes_cbc_pkg::CFG_KEY_HIGH, kh);
    write_cfg(aes_cbc_pkg::CFG_KEY_LOW, kl);
    write_cfg(aes_cbc_pkg::CFG_IV_HIGH, vh);
    write_cfg(aes_cbc_pkg::CFG_IV_LOW, vl);
    write_cfg(aes_cbc_pkg::CFG_DECRYPT, {63'b0, dec});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait until every predicted beat has been seen, then settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic send_block(blk_beat_t it);
    int gap;
    gap = $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b0, it.cnt, it.lo, it.hi};
    in_tuser <= it.first;
    in_tlast <= it.last;
    do @(posedge clk); while (!in_tready);
    sb.note_block(it);
    if (it.last) messages++;
  endtask

  task automatic send(logic [63:0] hi, logic [63:0] lo, logic [4:0] cnt, logic first,
                      logic last);
    blk_beat_t it;
    it.hi = hi; it.lo = lo; it.cnt = cnt; it.first = first; it.last = last;
    send_block(it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one random message; decrypt tails are mostly built to carry a chosen pad byte
  task automatic send_message();
    int len;
    aes_cbc_pkg::blk_t b;
    logic first;
    logic [4:0] cnt;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
      b = {rand64(), rand64()};
      case ($urandom_range(0, 3))
        0: cnt = 5'd16;
        1: cnt = 5'd0;
        default: cnt = 5'($urandom_range(0, 31));
      endcase
      if (sb.decrypt && i == len - 1 && $urandom_range(0, 9) < 7) begin
        b[7:0] = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 18));
        b = sb.cipher_for(b, first);
      end
      send(b[127:64], b[63:0], cnt, first, i == len - 1);
    end
  endtask

  initial begin
    aes_cbc_pkg::blk_t b;
    logic [7:0] tails [5];
    tails = '{8'h00, 8'h01, 8'h10, 8'h11, 8'hff};
    messages = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed encrypt under the reset key; first message starts with no vector load
    send('0, '0, 5'd0, 1'b0, 1'b0);
    send('1, '1, 5'd31, 1'b0, 1'b1);
    send('1, '0, 5'd0, 1'b1, 1'b1);           // pad block only
    send(64'h0123456789abcdef, '1, 5'd1, 1'b1, 1'b1);
    send('0, '1, 5'd15, 1'b1, 1'b1);
    send(64'hdeadbeefcafef00d, '0, 5'd16, 1'b1, 1'b1); // full block plus pad block
    send('1, '1, 5'd17, 1'b1, 1'b1);          // count saturates to full
    drain();

    // directed decrypt: final bytes at the pad limits and beyond
    setup('1, '1, '1, '1, 1'b1);
    for (int k = 0; k < 5; k++) begin
      b = '0;
      b[7:0] = tails[k];
      send('1, '0, 5'd31, 1'b1, 1'b0);
      b = sb.cipher_for(b, 1'b0);
      send(b[127:64], b[63:0], 5'd0, 1'b0, 1'b1);
    end
    send('0, '0, 5'd0, 1'b0, 1'b1);
    drain();

    // random phases over key extremes, random keys and both directions
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: setup('0, '0, '0, '0, 1'b0);
        1: setup('1, '1, '1, '1, 1'b0);
        2: setup('0, '0, '1, '0, 1'b1);
        default: setup(rand64(), rand64(), rand64(), rand64(), ph[0]);
      endcase
      while (sb.accepted < 155 * (ph + 1)) begin
        send_message();
        // in phase 4, after each message that leaves 701 to 709 blocks accepted, hold off until the core has emptied
        if (ph == 4 && sb.accepted > 700 && sb.accepted < 710) begin
          in_tvalid <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("covered %0d input blocks in %0d messages, %0d result beats checked",
             sb.accepted, messages, sb.results);
    $display("encrypt and decrypt, pad corners, chaining without vector load, 10 cfg sets");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
